// ===== sv/cfm_pkg.sv =====
// ---------------------------------------------------------------------------
// cfm_pkg
// Shared widths, register indexes and divider handshake types for the
// capture frequency meter.
// ---------------------------------------------------------------------------
package cfm_pkg;

    // payload widths
    localparam int PERIOD_W   = 32;
    localparam int FREQ_W     = 16;
    localparam int SUM_W      = 24;
    localparam int COUNT_W    = 9;

    // batch length in averaging mode (1 to 256)
    localparam int SAMPLES    = 32;

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_SINGLE_MODE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_REF_CLOCK   = CFG_IDX_W'(1);

    localparam logic [PERIOD_W-1:0] REF_CLOCK_RESET = PERIOD_W'(150000000);

    // event counter marks
    localparam logic [COUNT_W-1:0] COUNT_ONE  = COUNT_W'(1);
    localparam logic [COUNT_W-1:0] COUNT_TWO  = COUNT_W'(2);
    localparam logic [COUNT_W-1:0] COUNT_EMIT = COUNT_W'(SAMPLES + 1);

    localparam logic [FREQ_W-1:0] FREQ_MAX = '1;

    // divider sequencing
    localparam int DIV_STEPS = PERIOD_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

    typedef struct packed {
        logic                start;
        logic [PERIOD_W-1:0] dividend;
        logic [PERIOD_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic                done;
        logic [PERIOD_W-1:0] quotient;
    } t_div_rsp;

endpackage

// ===== sv/cfm_capture_if.sv =====
// ---------------------------------------------------------------------------
// cfm_capture_if
// Valid/ready channel carrying one captured period count per beat.
// ---------------------------------------------------------------------------
interface cfm_capture_if;
    import cfm_pkg::*;

    logic                valid;
    logic                ready;
    logic [PERIOD_W-1:0] period_count;

    modport source (output valid, output period_count, input ready);
    modport sink   (input valid, input period_count, output ready);

endinterface

// ===== sv/cfm_result_if.sv =====
// ---------------------------------------------------------------------------
// cfm_result_if
// Valid/ready channel carrying one frequency result per beat.
// ---------------------------------------------------------------------------
interface cfm_result_if;
    import cfm_pkg::*;

    logic              valid;
    logic              ready;
    logic [FREQ_W-1:0] frequency_hz;
    logic              clamped;

    modport source (output valid, output frequency_hz, output clamped, input ready);
    modport sink   (input valid, input frequency_hz, input clamped, output ready);

endinterface

// ===== sv/capture_frequency_meter_core.sv =====
// ---------------------------------------------------------------------------
// capture_frequency_meter_core
// Reciprocal frequency meter: reference clock divided by captured period,
// saturated to 16 bits, reported alone or as a batch mean.
// ---------------------------------------------------------------------------
// usage
//   i_capture takes one period count per beat; o_result gives one frequency
//   and a clamp flag per finished pair (single mode) or batch (averaging).
//   the user writes registers over i_cfg_* only while the block is idle;
//   the block itself does not enforce this.
// sequencing
//   the first capture of a batch or pair only opens it; i_capture stays ready.
//   any other capture runs a 32-step shared divider, one quotient bit per cycle;
//   i_capture is ready again once the divide ends and any result beat is taken.
//   the batch mean is a shift of the running sum and needs no extra state.
// reset
//   synchronous active-low reset restores averaging mode, a 150 MHz
//   reference and an empty batch; no result is pending afterwards.
// stall
//   a pending result holds until taken; no capture is accepted meanwhile.
// ---------------------------------------------------------------------------
module capture_frequency_meter_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [cfm_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [cfm_pkg::CFG_DATA_W-1:0] i_cfg_data,
    cfm_capture_if.sink                    i_capture,
    cfm_result_if.source                   o_result
);
    import cfm_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_FREQ = 3'b010,
        S_OUT  = 3'b100
    } t_state;

    t_state              r_state, n_state;
    logic                r_single_mode;
    logic [PERIOD_W-1:0] r_ref_clk;
    logic [COUNT_W-1:0]  r_count, n_count;
    logic [SUM_W-1:0]    r_sum, n_sum;
    logic                r_clamp, n_clamp;
    logic [FREQ_W-1:0]   r_out_freq, n_out_freq;
    logic                r_out_clamp, n_out_clamp;

    t_div_req            w_div_req;
    t_div_rsp            w_div_rsp;
    logic [COUNT_W-1:0]  w_count_inc;
    logic [FREQ_W-1:0]   w_freq;
    logic                w_clip;
    logic [SUM_W-1:0]    w_sum_next;
    logic                w_in_beat;
    logic                w_out_beat;

    cfm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    assign w_in_beat   = i_capture.valid && i_capture.ready;
    assign w_out_beat  = o_result.valid && o_result.ready;
    assign w_count_inc = r_count + 1'b1;

    // saturate the quotient; a zero period gives an all-ones quotient
    always_comb begin
        w_clip     = |w_div_rsp.quotient[PERIOD_W-1:FREQ_W];
        w_freq     = w_clip ? FREQ_MAX : w_div_rsp.quotient[FREQ_W-1:0];
        w_sum_next = r_sum + SUM_W'(w_freq);
    end

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_sum       = r_sum;
        n_clamp     = r_clamp;
        n_out_freq  = r_out_freq;
        n_out_clamp = r_out_clamp;
        w_div_req.start    = 1'b0;
        w_div_req.dividend = r_ref_clk;
        w_div_req.divisor  = i_capture.period_count;

        unique case (r_state)
            S_IDLE: begin
                if (w_in_beat) begin
                    n_count = w_count_inc;
                    if (w_count_inc == COUNT_ONE) begin
                        // discarded capture opens a new batch or pair
                        n_sum   = '0;
                        n_clamp = 1'b0;
                    end else if (w_count_inc >= COUNT_TWO) begin
                        w_div_req.start = 1'b1;
                        n_state         = S_FREQ;
                    end
                end
            end
            S_FREQ: begin
                if (w_div_rsp.done) begin
                    if (r_single_mode) begin
                        n_out_freq  = w_freq;
                        n_out_clamp = w_clip;
                        n_count     = '0;
                        n_sum       = '0;
                        n_clamp     = 1'b0;
                        n_state     = S_OUT;
                    end else if (r_count >= COUNT_EMIT) begin
                        // batch complete: mean of the sum, power-of-two divide
                        n_out_freq  = FREQ_W'(w_sum_next / SUM_W'(SAMPLES));
                        n_out_clamp = r_clamp | w_clip;
                        n_count     = '0;
                        n_sum       = '0;
                        n_clamp     = 1'b0;
                        n_state     = S_OUT;
                    end else begin
                        n_sum   = w_sum_next;
                        n_clamp = r_clamp | w_clip;
                        n_state = S_IDLE;
                    end
                end
            end
            S_OUT: begin
                if (w_out_beat) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state and configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_single_mode <= 1'b0;
            r_ref_clk     <= REF_CLOCK_RESET;
            r_count       <= '0;
            r_sum         <= '0;
            r_clamp       <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_sum   <= n_sum;
            r_clamp <= n_clamp;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_SINGLE_MODE: r_single_mode <= i_cfg_data[0];
                    REG_REF_CLOCK:   r_ref_clk     <= i_cfg_data[PERIOD_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        r_out_freq  <= n_out_freq;
        r_out_clamp <= n_out_clamp;
    end

    assign i_capture.ready       = (r_state == S_IDLE);
    assign o_result.valid        = (r_state == S_OUT);
    assign o_result.frequency_hz = r_out_freq;
    assign o_result.clamped      = r_out_clamp;

endmodule

// ===== sv/cfm_div.sv =====
// ---------------------------------------------------------------------------
// cfm_div
// Restoring unsigned divider, one quotient bit per cycle. A zero divisor
// yields an all-ones quotient.
// ---------------------------------------------------------------------------
module cfm_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  cfm_pkg::t_div_req i_req,
    output cfm_pkg::t_div_rsp o_rsp
);
    import cfm_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [PERIOD_W-1:0]  r_rem;
    logic [PERIOD_W-1:0]  r_quo;
    logic [PERIOD_W-1:0]  r_dvs;

    logic [PERIOD_W:0]    w_shift;
    logic [PERIOD_W+1:0]  w_diff;
    logic                 w_fits;

    // trial subtract of the shifted partial remainder
    always_comb begin
        w_shift = {r_rem, r_quo[PERIOD_W-1]};
        w_diff  = {1'b0, w_shift} - {2'b00, r_dvs};
        w_fits  = ~w_diff[PERIOD_W+1];
    end

    // step counter and done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(DIV_STEPS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // remainder and quotient shift registers
    always_ff @(posedge i_clk) begin
        if (i_req.start && !r_busy) begin
            r_rem <= '0;
            r_quo <= i_req.dividend;
            r_dvs <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= w_fits ? w_diff[PERIOD_W-1:0] : w_shift[PERIOD_W-1:0];
            r_quo <= {r_quo[PERIOD_W-2:0], w_fits};
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

// ===== sv/cfm_checker.sv =====
// ---------------------------------------------------------------------------
// cfm_checker
// Port-level checks for the capture frequency meter, bound to the top level.
// ---------------------------------------------------------------------------
module cfm_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_in_valid,
    input logic                      i_in_ready,
    input logic                      i_out_valid,
    input logic                      i_out_ready,
    input logic [cfm_pkg::FREQ_W-1:0] i_frequency_hz,
    input logic                      i_clamped
);
    import cfm_pkg::*;

    // no capture is taken while a result beat is pending
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !i_in_ready)
        else $error("capture ready while result pending");

    // a result cannot follow its capture in the next cycle
    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_out_valid)
        else $error("result offered one cycle after capture");

    // one beat per result, then back to idle
    a_single_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_ready) |=> !i_out_valid)
        else $error("result repeated after beat");

    // stalled result holds its payload
    a_hold_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_frequency_hz) && $stable(i_clamped)))
        else $error("stalled result changed");

endmodule

bind capture_frequency_meter_core cfm_checker u_cfm_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_capture.valid),
    .i_in_ready     (i_capture.ready),
    .i_out_valid    (o_result.valid),
    .i_out_ready    (o_result.ready),
    .i_frequency_hz (o_result.frequency_hz),
    .i_clamped      (o_result.clamped)
);

// ===== test/tb_capture_frequency_meter_core.sv =====
// ---------------------------------------------------------------------------
// tb_capture_frequency_meter_core
// Self-checking bench for the capture frequency meter. Period captures are
// streamed into the core through a queue-fed driver. An in-bench predictor
// tracks the batch counter, the frequency sum and the clamp flag. Each result
// beat is checked field by field against the oldest predicted frequency.
// Register settings change between phases while the core is idle. Both sides
// insert random gaps, and one phase holds the result side off for a long
// stretch.
// ---------------------------------------------------------------------------
module tb_capture_frequency_meter_core;
    timeunit 1ns;
    timeprecision 1ps;

    import cfm_pkg::*;

    localparam int CLK_PERIOD    = 10;
    localparam int RESET_CYCLES  = 8;
    localparam int SETTLE_CYCLES = 100;
    localparam int HOLD_CYCLES   = 400;
    localparam int RANDOM_ITEMS  = 1500;
    localparam int MAX_REPORTS   = 10;
    localparam int CYCLE_LIMIT   = 2000000;

    typedef struct packed {
        logic [FREQ_W-1:0] freq_hz;
        logic              clamped;
    } t_freq_result;

    logic clk = 1'b0;
    logic rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    cfm_capture_if cap_if ();
    cfm_result_if  res_if ();

    capture_frequency_meter_core dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_capture  (cap_if),
        .o_result   (res_if)
    );

    // predicted register and batch state
    logic                model_single;
    logic [PERIOD_W-1:0] model_ref_hz;
    logic [COUNT_W-1:0]  batch_count;
    logic [SUM_W-1:0]    batch_sum;
    logic                batch_clamped;

    logic [PERIOD_W-1:0] capture_queue[$];
    t_freq_result        expected_freqs[$];

    int  error_count;
    int  cycle_count;
    int  gap_left;
    int  stall_left;
    int  hold_left;
    int  hold_requests;
    int  hold_served;
    bit  source_idle_en;
    bit  sink_idle_en;
    t_freq_result oldest;

    always #(CLK_PERIOD / 2) clk = ~clk;

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        return ($urandom_range(0, 9) < 8) ? int'($urandom_range(0, 3))
                                          : int'($urandom_range(20, 80));
    endfunction

    // frequency of one period, saturated, and the batch bookkeeping
    function automatic void predict_capture(input logic [PERIOD_W-1:0] period);
        logic [PERIOD_W-1:0] quot;
        logic [FREQ_W-1:0]   freq;
        logic                clip;
        batch_count = batch_count + 1'b1;
        if (batch_count == COUNT_ONE) begin
            batch_sum     = '0;
            batch_clamped = 1'b0;
            return;
        end
        if (period == '0) begin
            freq = FREQ_MAX;
            clip = 1'b1;
        end else begin
            quot = model_ref_hz / period;
            clip = (quot > FREQ_MAX);
            freq = clip ? FREQ_MAX : quot[FREQ_W-1:0];
        end
        if (model_single) begin
            expected_freqs.push_back('{freq_hz: freq, clamped: clip});
        end else begin
            batch_sum     = batch_sum + freq;
            batch_clamped = batch_clamped | clip;
            if (batch_count < COUNT_EMIT)
                return;
            expected_freqs.push_back('{freq_hz: FREQ_W'(batch_sum / SUM_W'(SAMPLES)),
                                       clamped: batch_clamped});
        end
        batch_count   = '0;
        batch_sum     = '0;
        batch_clamped = 1'b0;
    endfunction

    // period mix: zero, full range, tiny, near the clamp edge, huge, typical
    function automatic logic [PERIOD_W-1:0] random_period();
        logic [PERIOD_W:0] edge_period;
        int                pick;
        pick        = $urandom_range(0, 15);
        edge_period = model_ref_hz / FREQ_MAX + $urandom_range(0, 6);
        if (pick == 0)
            return '0;
        if (pick <= 3)
            return $urandom;
        if (pick == 4)
            return PERIOD_W'($urandom_range(1, 64));
        if (pick <= 6)
            return PERIOD_W'(edge_period > 3 ? edge_period - 3 : edge_period);
        if (pick == 7)
            return {16'hFFFF, 16'($urandom)};
        return PERIOD_W'(model_ref_hz / $urandom_range(1, 65535) + $urandom_range(0, 3));
    endfunction

    function automatic void flag_error(input string msg);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("%s", msg);
    endfunction

    // capture driver: pops pending periods, predicts on each accepted beat
    always @(posedge clk) begin
        if (!rst_n) begin
            cap_if.valid <= 1'b0;
            gap_left = 0;
        end else begin
            if (cap_if.valid && cap_if.ready)
                predict_capture(cap_if.period_count);
            if (!cap_if.valid || cap_if.ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    cap_if.valid <= 1'b0;
                end else if (capture_queue.size() != 0) begin
                    cap_if.valid        <= 1'b1;
                    cap_if.period_count <= capture_queue.pop_front();
                    gap_left = source_idle_en ? pick_gap() : 0;
                end else begin
                    cap_if.valid <= 1'b0;
                end
            end
        end
    end

    // result ready: long hold on request, random stalls otherwise
    always @(posedge clk) begin
        if (!rst_n) begin
            res_if.ready <= 1'b0;
            stall_left = 0;
            hold_left  = 0;
        end else begin
            if (hold_served != hold_requests) begin
                hold_served = hold_requests;
                hold_left   = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                res_if.ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= 1'b1;
                if (sink_idle_en && $urandom_range(0, 2) == 0)
                    stall_left = pick_gap();
            end
        end
    end

    // result monitor: compare each beat with the oldest predicted frequency
    always @(posedge clk) begin
        if (rst_n && res_if.valid && res_if.ready) begin
            if (expected_freqs.size() == 0) begin
                flag_error($sformatf("unexpected result: freq %0d clamped %0b",
                                     res_if.frequency_hz, res_if.clamped));
            end else begin
                oldest = expected_freqs.pop_front();
                if (res_if.frequency_hz !== oldest.freq_hz || res_if.clamped !== oldest.clamped)
                    flag_error($sformatf("mismatch: expected freq %0d clamped %0b, got freq %0d clamped %0b",
                                         oldest.freq_hz, oldest.clamped,
                                         res_if.frequency_hz, res_if.clamped));
            end
        end
    end

    // run limit
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
        if (idx == REG_SINGLE_MODE)
            model_single = data[0];
        else
            model_ref_hz = data;
    endtask

    // mode write with random upper data bits
    task automatic write_mode(input logic mode);
        logic [CFG_DATA_W-1:0] data;
        data    = $urandom;
        data[0] = mode;
        write_reg(REG_SINGLE_MODE, data);
    endtask

    // nothing pending, nothing in flight, then let the divider finish
    task automatic wait_idle();
        do
            @(negedge clk);
        while (capture_queue.size() != 0 || cap_if.valid || expected_freqs.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic run_phase(input logic mode, input logic [PERIOD_W-1:0] ref_hz,
                             input int n_items, input bit idle_on);
        wait_idle();
        write_mode(mode);
        write_reg(REG_REF_CLOCK, ref_hz);
        source_idle_en = idle_on && ($urandom_range(0, 3) != 0);
        sink_idle_en   = idle_on && ($urandom_range(0, 3) != 0);
        repeat (n_items) capture_queue.push_back(random_period());
    endtask

    // random reference clock, extremes included
    function automatic logic [PERIOD_W-1:0] random_ref_hz();
        case ($urandom_range(0, 7))
            0: return REF_CLOCK_RESET;
            1: return PERIOD_W'(1);
            2: return '1;
            3: return '0;
            4, 5: return $urandom;
            6: return PERIOD_W'($urandom_range(1000, 10000000));
            default: return PERIOD_W'($urandom_range(1, 2000) * 65535);
        endcase
    endfunction

    initial begin
        int random_items;
        int n;
        rst_n               = 1'b0;
        cfg_we              = 1'b0;
        cfg_idx             = REG_SINGLE_MODE;
        cfg_data            = '0;
        cap_if.valid        = 1'b0;
        cap_if.period_count = '0;
        res_if.ready        = 1'b0;
        model_single        = 1'b0;
        model_ref_hz        = REF_CLOCK_RESET;
        batch_count         = '0;
        batch_sum           = '0;
        batch_clamped       = 1'b0;
        error_count         = 0;
        cycle_count         = 0;
        hold_requests       = 0;
        hold_served         = 0;
        source_idle_en      = 1'b0;
        sink_idle_en        = 1'b0;
        random_items        = 0;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // single mode at the reset reference: zero period, tiny period,
        // longest period, both sides of the clamp edge
        wait_idle();
        write_mode(1'b1);
        write_reg(REG_REF_CLOCK, REF_CLOCK_RESET);
        capture_queue.push_back($urandom);
        capture_queue.push_back('0);
        capture_queue.push_back($urandom);
        capture_queue.push_back(PERIOD_W'(1));
        capture_queue.push_back($urandom);
        capture_queue.push_back('1);
        capture_queue.push_back($urandom);
        capture_queue.push_back(PERIOD_W'(2289));
        capture_queue.push_back($urandom);
        capture_queue.push_back(PERIOD_W'(2288));

        // largest reference: quotient just below and just at the limit
        wait_idle();
        write_reg(REG_REF_CLOCK, '1);
        capture_queue.push_back($urandom);
        capture_queue.push_back(PERIOD_W'(65538));
        capture_queue.push_back($urandom);
        capture_queue.push_back(PERIOD_W'(65537));

        // zero reference: nonzero period gives zero, zero period still clamps
        wait_idle();
        write_reg(REG_REF_CLOCK, '0);
        capture_queue.push_back($urandom);
        capture_queue.push_back(PERIOD_W'(5));
        capture_queue.push_back($urandom);
        capture_queue.push_back('0);

        // averaging batch cut short by a switch to single mode
        wait_idle();
        write_mode(1'b0);
        write_reg(REG_REF_CLOCK, REF_CLOCK_RESET);
        repeat (3) capture_queue.push_back(random_period());
        wait_idle();
        write_mode(1'b1);
        capture_queue.push_back(random_period());

        // fixed random phases covering both modes, the reset reference and the largest one
        run_phase(1'b0, REF_CLOCK_RESET, 200, 1'b1);
        random_items += 200;
        run_phase(1'b1, '1, 100, 1'b1);
        random_items += 100;

        // long result hold while captures keep coming
        wait_idle();
        write_mode(1'b1);
        source_idle_en = 1'b0;
        sink_idle_en   = 1'b0;
        hold_requests++;
        repeat (60) capture_queue.push_back(random_period());
        random_items += 60;

        run_phase(1'b0, PERIOD_W'(1), 100, 1'b1);
        random_items += 100;
        run_phase(1'b1, '0, 60, 1'b0);
        random_items += 60;
        run_phase(1'b0, '1, 120, 1'b0);
        random_items += 120;

        // random settings; phase lengths leave batches open across changes
        while (random_items < RANDOM_ITEMS) begin
            n = $urandom_range(40, 180);
            run_phase(1'($urandom_range(0, 1)), random_ref_hz(), n, 1'($urandom_range(0, 4) != 0));
            random_items += n;
        end

        wait_idle();
        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ===== capture_frequency_meter_core.f =====
sv/cfm_pkg.sv
sv/cfm_capture_if.sv
sv/cfm_result_if.sv
sv/cfm_div.sv
sv/capture_frequency_meter_core.sv
sv/cfm_checker.sv
test/tb_capture_frequency_meter_core.sv
